@@ hw/rtl/yuv2rgb_pkg.sv @@
// Shared types and constants for the 4:2:0 YCbCr to RGB scan converter.
// No dependencies.
package yuv2rgb_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int DIM_W     = 14;   // holds a 13-bit size register or a limit up to 8192
    localparam int SIZE_W    = 13;
    localparam int SLOT_W    = 7;
    localparam int BYTES_W   = 27;
    localparam int PIX_W     = 24;
    localparam int CHROMA_W  = 22;
    localparam int DEST_W    = 33;

    localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1920;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd1080;
    localparam logic [SLOT_W-1:0]  SLOT_RST   = 7'd0;
    localparam logic [BYTES_W-1:0] BYTES_RST  = 27'd8388608;

    // Fixed-point coefficients over 256.
    localparam logic signed [19:0] COEF_R_CR = 20'sd359;
    localparam logic signed [19:0] COEF_G_CB = 20'sd88;
    localparam logic signed [19:0] COEF_G_CR = 20'sd183;
    localparam logic signed [19:0] COEF_B_CB = 20'sd454;
    localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;
    localparam logic signed [12:0] CHAN_MAX   = 13'sd255;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FRAME_SLOT   = 2'd2,
        REG_FRAME_BYTES  = 2'd3
    } cfg_reg_t;

endpackage

@@ hw/rtl/yuv420_planar_to_rgb_scan.sv @@
// Top level: 4:2:0 YCbCr to RGB converter with raster counters and address generation.
// Depends on yuv2rgb_pkg.
//
//   channel   signals                                   dir   beat
//   in        in_valid/in_ready, luma cb cr             in    one pixel
//   out       out_valid/out_ready, red green blue,      out   one converted pixel
//             luma_index chroma_index dest_offset,
//             end_of_line end_of_frame
//   cfg       psel penable pwrite paddr pwdata prdata   in    APB register access
//
// One pixel per clock sustained while out_ready is high; the outputs are registered in the result register.
// A pixel is converted and its indices formed in the cycle it is accepted.
// in_ready drops only while a result is held and out_ready is low.
// rst_n clears the counters, the result valid and loads the register defaults.
module yuv420_planar_to_rgb_scan #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           luma,
    input  logic [7:0]                           cb,
    input  logic [7:0]                           cr,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue,
    output logic [yuv2rgb_pkg::PIX_W-1:0]        luma_index,
    output logic [yuv2rgb_pkg::CHROMA_W-1:0]     chroma_index,
    output logic [yuv2rgb_pkg::DEST_W-1:0]       dest_offset,
    output logic                                 end_of_line,
    output logic                                 end_of_frame,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [yuv2rgb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [yuv2rgb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [yuv2rgb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import yuv2rgb_pkg::*;

    localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;

    function automatic logic [7:0] clamp8(input logic signed [12:0] v);
        logic [7:0] r;
        if (v < 13'sd0)
            r = 8'd0;
        else if (v > CHAN_MAX)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (DIM_W'(v) > DIM_W'(MAX_DIMENSION))
            r = DIM_W'(MAX_DIMENSION);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // configuration
    logic [SIZE_W-1:0]  frame_width_reg;
    logic [SIZE_W-1:0]  frame_height_reg;
    logic [SLOT_W-1:0]  frame_slot_reg;
    logic [BYTES_W-1:0] frame_bytes_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_sel;

    // scan counters
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;
    logic [PIX_W-1:0] pixel_count_reg, pixel_count_next;

    // result stage
    logic                out_valid_reg;
    logic [7:0]          red_reg, green_reg, blue_reg;
    logic [PIX_W-1:0]    luma_index_reg;
    logic [CHROMA_W-1:0] chroma_index_reg;
    logic [DEST_W-1:0]   dest_offset_reg;
    logic                eol_reg, eof_reg;

    logic in_fire;

    // datapath
    logic signed [9:0]  u_s, v_s;
    logic signed [19:0] u_w, v_w;
    logic signed [19:0] r_prod, g_prod, b_prod;
    logic signed [12:0] y_s, dr, dg, db;
    logic [DIM_W-1:0]   w_eff, h_eff, w_last, h_last;
    logic               eol, eof;
    logic [31:0]        chroma_full;
    logic [34:0]        dest_full;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            REG_FRAME_SLOT:   prdata = APB_DATA_W'(frame_slot_reg);
            REG_FRAME_BYTES:  prdata = APB_DATA_W'(frame_bytes_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
            frame_slot_reg   <= SLOT_RST;
            frame_bytes_reg  <= BYTES_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[SIZE_W-1:0];
                REG_FRAME_SLOT:   frame_slot_reg   <= pwdata[SLOT_W-1:0];
                REG_FRAME_BYTES:  frame_bytes_reg  <= pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // color conversion
    always_comb
    begin
        y_s    = $signed({5'b00000, luma});
        u_s    = $signed({2'b00, cb}) - CHROMA_OFS;
        v_s    = $signed({2'b00, cr}) - CHROMA_OFS;
        u_w    = {{10{u_s[9]}}, u_s};
        v_w    = {{10{v_s[9]}}, v_s};
        r_prod = v_w * COEF_R_CR;
        g_prod = u_w * COEF_G_CB + v_w * COEF_G_CR;
        b_prod = u_w * COEF_B_CB;
        dr     = {{1{r_prod[19]}}, r_prod[19:8]};
        dg     = {{1{g_prod[19]}}, g_prod[19:8]};
        db     = {{1{b_prod[19]}}, b_prod[19:8]};
    end

    // scan position
    always_comb
    begin
        w_eff  = clamp_dim(frame_width_reg);
        h_eff  = clamp_dim(frame_height_reg);
        w_last = w_eff - DIM_W'(1);
        h_last = h_eff - DIM_W'(1);
        eol    = DIM_W'(column_count_reg) >= w_last;
        eof    = eol && (DIM_W'(row_count_reg) >= h_last);

        chroma_full = 32'(row_count_reg >> 1) * 32'(w_eff >> 1)
                    + 32'(column_count_reg >> 1);
        dest_full   = 35'(frame_slot_reg) * 35'(frame_bytes_reg)
                    + {9'd0, pixel_count_reg, 2'b00};

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pixel_count_next  = pixel_count_reg;
        if (eof)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            pixel_count_next  = '0;
        end
        else
        begin
            if (eol)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + CNT_W'(1);
            end
            else
                column_count_next = column_count_reg + CNT_W'(1);
            pixel_count_next = pixel_count_reg + PIX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pixel_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                pixel_count_reg  <= pixel_count_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            red_reg          <= clamp8(y_s + dr);
            green_reg        <= clamp8(y_s - dg);
            blue_reg         <= clamp8(y_s + db);
            luma_index_reg   <= pixel_count_reg;
            chroma_index_reg <= chroma_full[CHROMA_W-1:0];
            dest_offset_reg  <= dest_full[DEST_W-1:0];
            eol_reg          <= eol;
            eof_reg          <= eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign luma_index   = luma_index_reg;
    assign chroma_index = chroma_index_reg;
    assign dest_offset  = dest_offset_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule
